/* hw/rtl/pal_pkg.sv */
// pal_pkg: shared types and constants for the positional array list
// request/result payload structs, operation and status codes, controller commands
// no dependencies

package pal_pkg;

	localparam int CAPACITY = 16;
	localparam int ELEM_W   = 32;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 5;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic [POS_W-1:0]        position;
		logic signed [ELEM_W-1:0] item;
	} req_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] data;
		logic [1:0]              status;
		logic [FILL_W-1:0]       count;
		logic                    empty_res;
		logic                    full_res;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic exec;
	} cmd_t;

endpackage

/* hw/rtl/pal_ctrl.sv */
// pal_ctrl: controller state machine for the positional array list
// sequences request capture, execution and the result valid flag
// depends on pal_pkg

module pal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pal_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				// wait for the result register to free up
				if (slot_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/pal_datapath.sv */
// pal_datapath: request register, row of list cells, fill count and result register
// every cell picks its neighbor, the new item or itself
// depends on pal_pkg

module pal_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  pal_pkg::cmd_t cmd,
	input  pal_pkg::req_t req,
	output pal_pkg::rsp_t rsp
);

	pal_pkg::req_t req_s1;
	pal_pkg::rsp_t rsp_q;
	pal_pkg::rsp_t rsp_d;

	logic [pal_pkg::ELEM_W-1:0] cells_q [pal_pkg::CAPACITY];
	logic [pal_pkg::ELEM_W-1:0] cells_d [pal_pkg::CAPACITY];
	logic [pal_pkg::FILL_W-1:0] fill_q, fill_d;

	logic [pal_pkg::FILL_W-1:0] pos_w;
	logic                       is_full;
	logic                       ins_ok, app_ok, del_ok, rd_ok;
	logic [pal_pkg::ELEM_W-1:0] sel_entry;

	assign pos_w     = {1'b0, req_s1.position};
	assign is_full   = (fill_q == pal_pkg::FILL_W'(pal_pkg::CAPACITY));
	assign sel_entry = cells_q[req_s1.position];

	assign ins_ok = (req_s1.func == pal_pkg::OP_INSERT) && !is_full && (pos_w <= fill_q);
	assign app_ok = (req_s1.func == pal_pkg::OP_APPEND) && !is_full;
	assign del_ok = (req_s1.func == pal_pkg::OP_DELETE) && (pos_w < fill_q);
	assign rd_ok  = (req_s1.func == pal_pkg::OP_READ) && (pos_w < fill_q);

	always_comb begin
		for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
			cells_d[i] = cells_q[i];
			if (ins_ok) begin
				if (pal_pkg::FILL_W'(i) == pos_w) begin
					cells_d[i] = req_s1.item;
				end else if (i > 0 && pal_pkg::FILL_W'(i) > pos_w
				             && pal_pkg::FILL_W'(i) <= fill_q) begin
					cells_d[i] = cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (app_ok) begin
				if (pal_pkg::FILL_W'(i) == fill_q) begin
					cells_d[i] = req_s1.item;
				end
			end else if (del_ok) begin
				if (i < pal_pkg::CAPACITY - 1 && pal_pkg::FILL_W'(i) >= pos_w
				    && pal_pkg::FILL_W'(i + 1) < fill_q) begin
					cells_d[i] = cells_q[(i < pal_pkg::CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		fill_d       = fill_q;
		rsp_d.data   = '0;
		rsp_d.status = pal_pkg::ST_OK;
		case (req_s1.func)
			pal_pkg::OP_INSERT: begin
				if (is_full) begin
					rsp_d.status = pal_pkg::ST_FULL;
				end else if (!ins_ok) begin
					rsp_d.status = pal_pkg::ST_BADPOS;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			pal_pkg::OP_APPEND: begin
				if (is_full) begin
					rsp_d.status = pal_pkg::ST_FULL;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			pal_pkg::OP_DELETE: begin
				if (del_ok) begin
					rsp_d.data = sel_entry;
					fill_d     = fill_q - 1'b1;
				end else begin
					rsp_d.status = pal_pkg::ST_BADPOS;
				end
			end
			default: begin
				if (rd_ok) begin
					rsp_d.data = sel_entry;
				end else begin
					rsp_d.status = pal_pkg::ST_BADPOS;
				end
			end
		endcase
		rsp_d.count     = fill_d;
		rsp_d.empty_res = (fill_d == '0);
		rsp_d.full_res  = (fill_d == pal_pkg::FILL_W'(pal_pkg::CAPACITY));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.exec) begin
			fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_s1 <= req;
		end
		if (cmd.exec) begin
			cells_q <= cells_d;
			rsp_q   <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

/* hw/rtl/positional_array_list_core.sv */
// positional_array_list_core: top level of the positional array list
// joins the controller (pal_ctrl) and the datapath (pal_datapath); uses pal_pkg

// A bounded ordered list of 16 signed 32-bit entries with insert at a
// position, append, delete at a position and read. Each request transfer on
// req gives exactly one result transfer on rsp carrying the data (the entry
// read or removed, zero otherwise), a status (ok, full, bad position), the
// entry count after the operation and empty/full flags. Refused requests
// leave the list unchanged. A request is captured in the request register;
// then, once the result register is free, the whole row of cells shifts
// and the result register loads. No new request is taken until the
// captured one has executed, but one is taken while an earlier result
// still waits in the result register; execution stalls only while that
// register is occupied and not being drained. No clearing pass follows
// reset: the count resets to zero and cells are only read below the count.

module positional_array_list_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pal_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pal_pkg::rsp_t rsp
);

	// command bundle from controller to datapath
	pal_pkg::cmd_t cmd;

	// sequencing: capture, execute when the result slot is free, hold valid
	pal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// list cells, fill count and result register
	pal_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

`ifndef SYNTH
	// execution never overwrites a result that has not been transferred
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (!rsp_valid || rsp_ready))
		else $error("result overwritten before transfer");

	// count never exceeds capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.count <= pal_pkg::FILL_W'(pal_pkg::CAPACITY)))
		else $error("count above capacity");

	// flags agree with the count
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.empty_res == (rsp.count == '0)) &&
		(rsp.full_res == (rsp.count == pal_pkg::FILL_W'(pal_pkg::CAPACITY)))))
		else $error("empty/full flags disagree with count");

	// refused requests carry zero data
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != pal_pkg::ST_OK) |-> (rsp.data == '0))
		else $error("refused request returned data");
`endif

endmodule
